[design/assert_macros.svh]
// Assertion macros used by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[design/ifp_pkg.sv]
// Shared types, codes and helpers of the infix-to-postfix converter.
package ifp_pkg;

  // Fixed field widths
  localparam int KIND_W  = 4;
  localparam int OKIND_W = 3;
  localparam int PAY_W   = 16;
  localparam int ERR_W   = 2;

  // Input token kinds
  localparam logic [KIND_W-1:0] K_END   = 4'd0;
  localparam logic [KIND_W-1:0] K_NUM   = 4'd1;
  localparam logic [KIND_W-1:0] K_PLUS  = 4'd2;
  localparam logic [KIND_W-1:0] K_MINUS = 4'd3;
  localparam logic [KIND_W-1:0] K_STAR  = 4'd4;
  localparam logic [KIND_W-1:0] K_SLASH = 4'd5;
  localparam logic [KIND_W-1:0] K_OPEN  = 4'd6;
  localparam logic [KIND_W-1:0] K_CLOSE = 4'd7;

  // Emitted kind of an end marker or error report
  localparam logic [OKIND_W-1:0] O_END = 3'd0;

  // Error codes
  localparam logic [ERR_W-1:0] E_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] E_CLOSE = 2'd1;
  localparam logic [ERR_W-1:0] E_OPEN  = 2'd2;
  localparam logic [ERR_W-1:0] E_OVF   = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  // Per-cycle action of the token sequencer
  typedef enum logic [2:0] {
    ACT_WAIT,
    ACT_DROP,
    ACT_POP,
    ACT_PUSH,
    ACT_DISCARD,
    ACT_RESULT,
    ACT_FAIL
  } act_t;

  // One result transfer from the sequencer to the output register
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [OKIND_W-1:0] kind;
    logic [PAY_W-1:0]   pay;
    logic [ERR_W-1:0]   err;
  } res_t;

  // Operator precedence; zero for anything that is not an operator
  function automatic logic [1:0] prec_of(input logic [KIND_W-1:0] k);
    logic [1:0] p;
    p = 2'd0;
    if (k == K_PLUS || k == K_MINUS) p = 2'd1;
    if (k == K_STAR || k == K_SLASH) p = 2'd2;
    return p;
  endfunction

endpackage

[design/ifp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ifp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

[design/ifp_ctrl.sv]
// Token sequencer: stack level, pop loop over the stack RAM, pending result.
`include "assert_macros.svh"
module ifp_ctrl #(
  parameter int STACK_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 16,
  localparam int AW = $clog2(STACK_DEPTH),
  localparam int LW = $clog2(STACK_DEPTH + 1),
  localparam int PW = (PAYLOAD_BITS < ifp_pkg::PAY_W) ? PAYLOAD_BITS : ifp_pkg::PAY_W,
  localparam int EW = PW + ifp_pkg::OKIND_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ifp_pkg::KIND_W-1:0]   tok_kind,
  input  logic [ifp_pkg::PAY_W-1:0]    tok_pay,
  input  logic                         out_slot,
  output ifp_pkg::res_t                res,
  output logic [AW-1:0]                rd_addr,
  input  logic [EW-1:0]                rd_data,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [EW-1:0]                wr_data
);
  import ifp_pkg::*;

  state_t             state_r, state_nxt;
  act_t               act, act_raw;
  logic [ERR_W-1:0]   err_code;
  logic [KIND_W-1:0]  tok_kind_r;
  logic [PW-1:0]      tok_pay_r;
  logic [LW-1:0]      level_r, level_nxt, level_dec;
  logic [LW-1:0]      open_cnt_r, open_cnt_nxt;
  logic               failed_r, failed_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [OKIND_W-1:0] pend_kind_r, pend_kind_nxt;
  logic [PW-1:0]      pend_pay_r, pend_pay_nxt;
  logic [ERR_W-1:0]   pend_err_r, pend_err_nxt;
  logic [OKIND_W-1:0] tos_kind;
  logic [PW-1:0]      tos_pay;
  logic [1:0]         tos_prec, tok_prec;
  logic               stack_empty, stack_full, can_emit, emits;

  assign tos_kind = rd_data[OKIND_W-1:0];
  assign tos_pay  = rd_data[EW-1:OKIND_W];
  // A new result may enter the pending slot if that slot can drain
  assign can_emit = !pend_v_r || out_slot;

  // Decode what the current token does this cycle
  always_comb begin
    tos_prec    = prec_of({1'b0, tos_kind});
    tok_prec    = prec_of(tok_kind_r);
    stack_empty = (level_r == '0);
    stack_full  = (level_r == LW'(STACK_DEPTH));
    act_raw     = ACT_DROP;
    err_code    = E_NONE;
    priority if (failed_r) begin
      if (tok_kind_r == K_END) act_raw = ACT_RESULT;
    end else if (tok_kind_r == K_END) begin
      if (open_cnt_r != '0) begin
        act_raw  = ACT_FAIL;
        err_code = E_OPEN;
      end else if (!stack_empty) begin
        act_raw = ACT_POP;
      end else begin
        act_raw = ACT_RESULT;
      end
    end else if (tok_kind_r == K_NUM) begin
      act_raw = ACT_RESULT;
    end else if (tok_prec != 2'd0) begin
      if (!stack_empty && tos_prec >= tok_prec) begin
        act_raw = ACT_POP;
      end else if (stack_full) begin
        act_raw  = ACT_FAIL;
        err_code = E_OVF;
      end else begin
        act_raw = ACT_PUSH;
      end
    end else if (tok_kind_r == K_OPEN) begin
      if (stack_full) begin
        act_raw  = ACT_FAIL;
        err_code = E_OVF;
      end else begin
        act_raw = ACT_PUSH;
      end
    end else if (tok_kind_r == K_CLOSE) begin
      if (!stack_empty && {1'b0, tos_kind} != K_OPEN) begin
        act_raw = ACT_POP;
      end else if (!stack_empty) begin
        act_raw = ACT_DISCARD;
      end else begin
        act_raw  = ACT_FAIL;
        err_code = E_CLOSE;
      end
    end else begin
      act_raw = ACT_DROP;
    end
    emits = (act_raw == ACT_POP) || (act_raw == ACT_RESULT) || (act_raw == ACT_FAIL);
    if (state_r != S_WORK || (emits && !can_emit)) act = ACT_WAIT;
    else act = act_raw;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = S_WORK;
      S_WORK: if (act != ACT_WAIT && act != ACT_POP) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates and outputs
  always_comb begin
    level_nxt     = level_r;
    open_cnt_nxt  = open_cnt_r;
    failed_nxt    = failed_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_pay_nxt  = pend_pay_r;
    pend_err_nxt  = pend_err_r;
    res           = '0;
    in_ready      = 1'b0;
    wr_en         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // pending result is the last one of its token
        in_ready = !pend_v_r || out_slot;
        if (pend_v_r && out_slot) begin
          res.vld    = 1'b1;
          res.last   = 1'b1;
          res.kind   = pend_kind_r;
          res.pay    = PAY_W'(pend_pay_r);
          res.err    = pend_err_r;
          pend_v_nxt = 1'b0;
        end
      end
      S_WORK: begin
        // a fresh result pushes the pending one out, not last
        if (act == ACT_POP || act == ACT_RESULT || act == ACT_FAIL) begin
          if (pend_v_r) begin
            res.vld  = 1'b1;
            res.last = 1'b0;
            res.kind = pend_kind_r;
            res.pay  = PAY_W'(pend_pay_r);
            res.err  = pend_err_r;
          end
          pend_v_nxt = 1'b1;
        end
        unique case (act)
          ACT_POP: begin
            pend_kind_nxt = tos_kind;
            pend_pay_nxt  = tos_pay;
            pend_err_nxt  = E_NONE;
            level_nxt     = level_r - 1'b1;
          end
          ACT_RESULT: begin
            pend_kind_nxt = tok_kind_r[OKIND_W-1:0];
            pend_pay_nxt  = tok_pay_r;
            pend_err_nxt  = E_NONE;
            if (tok_kind_r == K_END) begin
              level_nxt    = '0;
              open_cnt_nxt = '0;
              failed_nxt   = 1'b0;
            end
          end
          ACT_FAIL: begin
            pend_kind_nxt = O_END;
            pend_pay_nxt  = tok_pay_r;
            pend_err_nxt  = err_code;
            level_nxt     = '0;
            open_cnt_nxt  = '0;
            failed_nxt    = (err_code != E_OPEN);
          end
          ACT_PUSH: begin
            wr_en     = 1'b1;
            level_nxt = level_r + 1'b1;
            if (tok_kind_r == K_OPEN) open_cnt_nxt = open_cnt_r + 1'b1;
          end
          ACT_DISCARD: begin
            level_nxt    = level_r - 1'b1;
            open_cnt_nxt = open_cnt_r - 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Stack RAM ports: the read always follows the next top of stack.
  // A push always returns to idle, so the top is re-read before it is used.
  assign level_dec = level_nxt - 1'b1;
  assign rd_addr   = level_dec[AW-1:0];
  assign wr_addr   = level_r[AW-1:0];
  assign wr_data   = {tok_pay_r, tok_kind_r[OKIND_W-1:0]};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      level_r    <= '0;
      open_cnt_r <= '0;
      failed_r   <= 1'b0;
      pend_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      level_r    <= level_nxt;
      open_cnt_r <= open_cnt_nxt;
      failed_r   <= failed_nxt;
      pend_v_r   <= pend_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok_kind_r <= tok_kind;
      tok_pay_r  <= tok_pay[PW-1:0];
    end
    pend_kind_r <= pend_kind_nxt;
    pend_pay_r  <= pend_pay_nxt;
    pend_err_r  <= pend_err_nxt;
  end

  `ASSERT_ALWAYS(a_level_bound, clk, rst_n, level_r <= LW'(STACK_DEPTH), "stack level beyond depth")
  `ASSERT_ALWAYS(a_open_bound, clk, rst_n, open_cnt_r <= level_r, "open count above stack level")
  `ASSERT_ALWAYS(a_failed_empty, clk, rst_n, !failed_r || (level_r == '0), "stack not empty while failed")
  `ASSERT_ALWAYS(a_res_slot, clk, rst_n, !res.vld || out_slot, "result transfer into a full output register")
  `ASSERT_NEXT(a_push_level, clk, rst_n, wr_en, level_r == $past(level_r) + 1'b1, "push did not raise level")

endmodule

[design/infix_to_postfix_converter.sv]
// Top level of the infix-to-postfix converter: stack RAM, sequencer, output register.
//
// Input stream: one infix token per transfer, kind in in_tuser, payload in
// in_tdata. Output stream: postfix tokens, end markers and error reports,
// with out_tlast on the final result that a token causes.
// The operator stack lives in a RAM with a registered read; the sequencer
// reads the top entry, decides, and pops one entry per cycle while the
// output does not stall; the pop loop through the RAM read sets this rate.
// A token is accepted in idle, then decided in the work state, which holds
// while it pops stacked operators (an end token: while it flushes entries).
// Each result enters a pending slot at the end of its decision cycle; the
// last one moves to the output register in the following idle cycle, so a
// number passes the token, pending and output registers before out_tvalid
// rises. Tokens that cause no result still pass through idle and work.
// Reset empties the stack and clears the error state; the stack RAM needs no
// clearing pass. When the receiver stalls, the output register and one
// pending result hold, the sequencer waits, and in_tready falls.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ifp_pkg::PAY_W-1:0]   in_tdata,   // [15:0] token_payload
  input  logic [ifp_pkg::KIND_W-1:0]  in_tuser,   // [3:0] token_kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ifp_pkg::PAY_W-1:0]   out_tdata,  // [15:0] out_payload
  output logic [ifp_pkg::OKIND_W+ifp_pkg::ERR_W-1:0] out_tuser, // [2:0] out_kind, [4:3] out_error
  output logic                        out_tlast
);
  import ifp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
  localparam int EW = PW + OKIND_W;

  logic               out_valid_r, out_valid_nxt;
  logic               out_last_r;
  logic [OKIND_W-1:0] out_kind_r;
  logic [PAY_W-1:0]   out_pay_r;
  logic [ERR_W-1:0]   out_err_r;
  logic               out_slot;
  res_t               res;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [EW-1:0]      rd_data, wr_data;
  logic               wr_en;

  // Operator stack storage
  ifp_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Token sequencer
  ifp_ctrl #(
    .STACK_DEPTH  (STACK_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .tok_kind (in_tuser),
    .tok_pay  (in_tdata),
    .out_slot (out_slot),
    .res      (res),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // Output register: free when empty or being taken this cycle
  assign out_slot = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.vld) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_last_r <= res.last;
      out_kind_r <= res.kind;
      out_pay_r  <= res.pay;
      out_err_r  <= res.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pay_r;
  assign out_tuser  = {out_err_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule
